>>> rtl/csv_tok_pkg.sv
// Shared constants and types for the CSV field tokenizer.
`timescale 1ns / 1ps

package csv_tok_pkg;

    // Default counter widths
    localparam int COUNT_BITS_DEF       = 32;
    localparam int FIELD_COUNT_BITS_DEF = 16;

    // Special characters
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_NUL   = 8'h00;

    // Per-byte token event from the parser
    typedef struct packed {
        logic       char_valid;
        logic [7:0] char_out;
        logic       field_end;
        logic       row_end;
        logic       row_malformed;
    } tok_event_t;

endpackage

>>> rtl/csv_field_tokenizer.sv
// Top level of the streaming CSV field tokenizer.
//
//  channel   handshake                   payload
//  input     byte_valid / byte_ready     data_byte, end_of_file
//  output    result_valid / result_ready char_valid .. bad_rows
//
// One byte per cycle sustained while result_ready is high; each byte's result
// passes the input register, then parse and the result register.
// The per-byte quote/row state is the only feedback loop.
// A stalled output holds both stages; the input register still fills while a
// result waits. Reset clears the parse state, counters and valid flags.
`timescale 1ns / 1ps

module csv_field_tokenizer
    import csv_tok_pkg::*;
#(
    parameter int COUNT_BITS       = COUNT_BITS_DEF,
    parameter int FIELD_COUNT_BITS = FIELD_COUNT_BITS_DEF
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        byte_valid,
    output logic                        byte_ready,
    input  logic [7:0]                  data_byte,
    input  logic                        end_of_file,
    output logic                        result_valid,
    input  logic                        result_ready,
    output logic                        char_valid,
    output logic [7:0]                  char_out,
    output logic                        field_end,
    output logic                        row_end,
    output logic                        row_malformed,
    output logic [FIELD_COUNT_BITS-1:0] row_field_count,
    output logic [COUNT_BITS-1:0]       rows_seen,
    output logic [COUNT_BITS-1:0]       fields_seen,
    output logic [FIELD_COUNT_BITS-1:0] widest_row,
    output logic [COUNT_BITS-1:0]       bad_rows
);

    logic                        in_vld_reg;
    logic [7:0]                  byte_reg;
    logic                        eof_reg;
    logic                        out_vld_reg;
    tok_event_t                  evt_reg;
    logic [FIELD_COUNT_BITS-1:0] rfc_reg;

    logic                        out_free, step;
    tok_event_t                  evt;
    logic [FIELD_COUNT_BITS-1:0] row_count;

    assign out_free   = !out_vld_reg || result_ready;
    assign step       = in_vld_reg && out_free;
    assign byte_ready = !in_vld_reg || out_free;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else if (byte_ready)
        begin
            in_vld_reg <= byte_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (byte_ready && byte_valid)
        begin
            byte_reg <= data_byte;
            eof_reg <= end_of_file;
        end
    end

    csv_tok_parse #(
        .FIELD_COUNT_BITS(FIELD_COUNT_BITS)
    ) u_parse (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (step),
        .data_byte  (byte_reg),
        .end_of_file(eof_reg),
        .event_out  (evt),
        .row_count  (row_count)
    );

    // Statistics registers load together with the result register
    csv_tok_stats #(
        .COUNT_BITS      (COUNT_BITS),
        .FIELD_COUNT_BITS(FIELD_COUNT_BITS)
    ) u_stats (
        .clk          (clk),
        .rst_n        (rst_n),
        .step         (step),
        .row_end      (evt.row_end),
        .row_malformed(evt.row_malformed),
        .row_count    (row_count),
        .rows_seen    (rows_seen),
        .fields_seen  (fields_seen),
        .widest_row   (widest_row),
        .bad_rows     (bad_rows)
    );

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_vld_reg <= in_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            evt_reg <= evt;
            rfc_reg <= row_count;
        end
    end

    assign result_valid    = out_vld_reg;
    assign char_valid      = evt_reg.char_valid;
    assign char_out        = evt_reg.char_out;
    assign field_end       = evt_reg.field_end;
    assign row_end         = evt_reg.row_end;
    assign row_malformed   = evt_reg.row_malformed;
    assign row_field_count = rfc_reg;

    // Checks
    a_malformed_needs_row_end: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && row_malformed |-> row_end)
        else $error("row_malformed without row_end");

    a_comma_no_char: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && field_end |-> !char_valid)
        else $error("field_end together with a character");

    a_rows_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> rows_seen >= $past(rows_seen))
        else $error("rows_seen decreased");

    a_bad_le_rows: assert property (@(posedge clk) disable iff (!rst_n)
        bad_rows <= rows_seen)
        else $error("bad_rows exceeds rows_seen");

endmodule

>>> rtl/csv_tok_parse.sv
// Quote/row state machine: decodes one byte per step into a token event.
`timescale 1ns / 1ps

module csv_tok_parse
    import csv_tok_pkg::*;
#(
    parameter int FIELD_COUNT_BITS = FIELD_COUNT_BITS_DEF
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        step,
    input  logic [7:0]                  data_byte,
    input  logic                        end_of_file,
    output tok_event_t                  event_out,
    output logic [FIELD_COUNT_BITS-1:0] row_count
);

    typedef enum logic [1:0] {
        MODE_UNQUOTED   = 2'd0,
        MODE_QUOTED     = 2'd1,
        MODE_QUOTE_SEEN = 2'd2,
        MODE_SKIP       = 2'd3
    } mode_t;

    localparam logic [FIELD_COUNT_BITS-1:0] FIELD_MAX = '1;

    mode_t                       mode_reg, mode_next;
    logic                        begun_reg, begun_next;
    logic [FIELD_COUNT_BITS-1:0] cnt_reg, cnt_next;

    logic is_lf, is_nul, is_term;
    logic unq, in_row, row_close, bad;

    assign is_lf   = (data_byte == CH_LF);
    assign is_nul  = (data_byte == CH_NUL);
    assign is_term = is_lf || is_nul;

    // Next state and event decode
    always_comb
    begin
        mode_next = mode_reg;
        begun_next = begun_reg;
        cnt_next = cnt_reg;
        event_out = '0;
        unq = 1'b0;
        in_row = 1'b0;
        row_close = 1'b0;
        bad = 1'b0;
        row_count = '0;

        unique case (mode_reg)
            MODE_SKIP:
            begin
                if (is_lf)
                begin
                    mode_next = MODE_UNQUOTED;
                end
            end
            MODE_QUOTED:
            begin
                if (is_term)
                begin
                    row_close = 1'b1;
                    bad = 1'b1;
                    mode_next = is_nul ? MODE_SKIP : MODE_UNQUOTED;
                end
                else
                begin
                    in_row = 1'b1;
                    if (data_byte == CH_QUOTE)
                    begin
                        mode_next = MODE_QUOTE_SEEN;
                    end
                    else
                    begin
                        event_out.char_valid = 1'b1;
                        event_out.char_out = data_byte;
                    end
                end
            end
            MODE_QUOTE_SEEN:
            begin
                if (data_byte == CH_QUOTE)
                begin
                    // doubled quote is a literal quote
                    in_row = 1'b1;
                    event_out.char_valid = 1'b1;
                    event_out.char_out = CH_QUOTE;
                    mode_next = MODE_QUOTED;
                end
                else
                begin
                    mode_next = MODE_UNQUOTED;
                    unq = 1'b1;
                end
            end
            MODE_UNQUOTED:
            begin
                unq = 1'b1;
            end
            default:
            begin
                unq = 1'b1;
            end
        endcase

        // Unquoted handling
        if (unq)
        begin
            if (is_term)
            begin
                row_close = 1'b1;
                mode_next = is_nul ? MODE_SKIP : MODE_UNQUOTED;
            end
            else
            begin
                in_row = 1'b1;
                if (data_byte == CH_COMMA)
                begin
                    event_out.field_end = 1'b1;
                    cnt_next = (cnt_reg == FIELD_MAX) ? cnt_reg : cnt_reg + 1'b1;
                    begun_next = 1'b0;
                end
                else if (data_byte == CH_CR)
                begin
                    // carriage return dropped
                end
                else if (data_byte == CH_QUOTE && !begun_reg)
                begin
                    mode_next = MODE_QUOTED;
                    begun_next = 1'b1;
                end
                else
                begin
                    event_out.char_valid = 1'b1;
                    event_out.char_out = data_byte;
                    begun_next = 1'b1;
                end
            end
        end

        // Flush an open row at end of file
        if (end_of_file && in_row && !row_close)
        begin
            row_close = 1'b1;
            bad = (mode_next == MODE_QUOTED);
        end

        if (row_close)
        begin
            row_count = (cnt_next == FIELD_MAX) ? cnt_next : cnt_next + 1'b1;
            cnt_next = '0;
            begun_next = 1'b0;
        end

        if (end_of_file)
        begin
            mode_next = MODE_UNQUOTED;
            begun_next = 1'b0;
        end

        event_out.row_end = row_close;
        event_out.row_malformed = row_close && bad;
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_UNQUOTED;
            begun_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else if (step)
        begin
            mode_reg <= mode_next;
            begun_reg <= begun_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

>>> rtl/csv_tok_stats.sv
// Saturating running statistics over ended rows.
`timescale 1ns / 1ps

module csv_tok_stats
    import csv_tok_pkg::*;
#(
    parameter int COUNT_BITS       = COUNT_BITS_DEF,
    parameter int FIELD_COUNT_BITS = FIELD_COUNT_BITS_DEF
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        step,
    input  logic                        row_end,
    input  logic                        row_malformed,
    input  logic [FIELD_COUNT_BITS-1:0] row_count,
    output logic [COUNT_BITS-1:0]       rows_seen,
    output logic [COUNT_BITS-1:0]       fields_seen,
    output logic [FIELD_COUNT_BITS-1:0] widest_row,
    output logic [COUNT_BITS-1:0]       bad_rows
);

    localparam int SUM_BITS =
        ((COUNT_BITS > FIELD_COUNT_BITS) ? COUNT_BITS : FIELD_COUNT_BITS) + 1;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
    localparam logic [SUM_BITS-1:0]   SUM_LIMIT = SUM_BITS'(COUNT_MAX);

    logic [COUNT_BITS-1:0]       rows_reg, fields_reg, bad_reg;
    logic [FIELD_COUNT_BITS-1:0] widest_reg;
    logic [SUM_BITS-1:0]         field_sum;

    assign field_sum = SUM_BITS'(fields_reg) + SUM_BITS'(row_count);

    // Counters update when a row closes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_reg <= '0;
            fields_reg <= '0;
            widest_reg <= '0;
            bad_reg <= '0;
        end
        else if (step && row_end)
        begin
            if (rows_reg != COUNT_MAX)
            begin
                rows_reg <= rows_reg + 1'b1;
            end
            fields_reg <= (field_sum > SUM_LIMIT) ? COUNT_MAX
                                                  : field_sum[COUNT_BITS-1:0];
            if (row_count > widest_reg)
            begin
                widest_reg <= row_count;
            end
            if (row_malformed && bad_reg != COUNT_MAX)
            begin
                bad_reg <= bad_reg + 1'b1;
            end
        end
    end

    assign rows_seen   = rows_reg;
    assign fields_seen = fields_reg;
    assign widest_row  = widest_reg;
    assign bad_rows    = bad_reg;

endmodule
